[sv/lj_pkg.sv]
package lj_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;

    // shift that leaves the bits above a 64-bit value scaled by 2^FRAC_BITS
    localparam int SH_HI = 64 - FRAC_BITS;

    // cap on intermediate magnitudes
    localparam logic [63:0] MID_CAP = 64'h4000_0000_0000_0000;

    // restoring divider length, one quotient bit per stage
    localparam int DIV_STEPS = 64;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CUTOFF_SQ  = 2'd0,
        CFG_SIGMA_SQ   = 2'd1,
        CFG_WELL_DEPTH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               in_cutoff;
        logic               saturated;
    } t_out;

    // per-item values that ride along the arithmetic units
    typedef struct packed {
        logic [31:0]      d;
        logic [2:0][32:0] mag;
        logic [2:0]       negr;
        logic             in_cut;
        logic             negf;
        logic             ovf;
        logic [63:0]      aux;
    } t_side;

endpackage

[sv/lj_mul.sv]
module lj_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_a,
    input  logic [63:0]    i_b,
    input  logic [63:0]    i_cap,
    input  lj_pkg::t_side  i_side,
    output logic           o_valid,
    output logic [63:0]    o_p,
    output lj_pkg::t_side  o_side
);

    logic [63:0]   w_ll, w_lh, w_hl, w_hh;
    logic [127:0]  w_sh;
    logic          w_big;

    logic          r_v1, r_v2, r_v3;
    logic [63:0]   r_ll, r_lh, r_hl, r_hh;
    logic [31:0]   r_lo;
    logic [33:0]   r_mid;
    logic [63:0]   r_hs;
    logic [127:0]  r_prod;
    logic [63:0]   r_cap1, r_cap2, r_cap3;
    lj_pkg::t_side r_side1, r_side2, r_side3;

    // 32x32 partial products
    assign w_ll = i_a[31:0]  * i_b[31:0];
    assign w_lh = i_a[31:0]  * i_b[63:32];
    assign w_hl = i_a[63:32] * i_b[31:0];
    assign w_hh = i_a[63:32] * i_b[63:32];

    // scale and clamp
    assign w_sh  = r_prod >> lj_pkg::FRAC_BITS;
    assign w_big = |w_sh[127:64];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    // product stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= w_ll;
            r_lh    <= w_lh;
            r_hl    <= w_hl;
            r_hh    <= w_hh;
            r_cap1  <= i_cap;
            r_side1 <= i_side;

            r_lo    <= r_ll[31:0];
            r_mid   <= 34'(r_ll[63:32]) + 34'(r_lh[31:0]) + 34'(r_hl[31:0]);
            r_hs    <= r_hh + 64'(r_lh[63:32]) + 64'(r_hl[63:32]);
            r_cap2  <= r_cap1;
            r_side2 <= r_side1;

            r_prod  <= {r_hs + 64'(r_mid[33:32]), r_mid[31:0], r_lo};
            r_cap3  <= r_cap2;
            r_side3 <= r_side2;

            o_p     <= (w_big || (w_sh[63:0] > r_cap3)) ? r_cap3 : w_sh[63:0];
            o_side  <= r_side3;
        end
    end

endmodule

[sv/lj_div.sv]
module lj_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_num,
    input  logic [31:0]    i_rem0,
    input  logic [31:0]    i_den,
    input  lj_pkg::t_side  i_side,
    output logic           o_valid,
    output logic [63:0]    o_quo,
    output lj_pkg::t_side  o_side
);

    logic          r_v    [lj_pkg::DIV_STEPS];
    logic [31:0]   r_rem  [lj_pkg::DIV_STEPS];
    logic [63:0]   r_nq   [lj_pkg::DIV_STEPS];
    logic [31:0]   r_den  [lj_pkg::DIV_STEPS];
    lj_pkg::t_side r_side [lj_pkg::DIV_STEPS];

    // one restoring step per stage; numerator bits shift out, quotient bits in
    for (genvar k = 0; k < lj_pkg::DIV_STEPS; k++) begin : g_step
        logic          w_vin;
        logic [31:0]   w_rin;
        logic [63:0]   w_nin;
        logic [31:0]   w_din;
        lj_pkg::t_side w_sin;
        logic [32:0]   w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_rin = i_rem0;
            assign w_nin = i_num;
            assign w_din = i_den;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_vin = r_v[k-1];
            assign w_rin = r_rem[k-1];
            assign w_nin = r_nq[k-1];
            assign w_din = r_den[k-1];
            assign w_sin = r_side[k-1];
        end

        assign w_trial = {w_rin, w_nin[63]};
        assign w_ge    = w_trial >= {1'b0, w_din};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 32'(w_trial - {1'b0, w_din}) : w_trial[31:0];
                r_nq[k]   <= {w_nin[62:0], w_ge};
                r_den[k]  <= w_din;
                r_side[k] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[lj_pkg::DIV_STEPS-1];
    assign o_quo   = r_nq[lj_pkg::DIV_STEPS-1];
    assign o_side  = r_side[lj_pkg::DIV_STEPS-1];

endmodule

[sv/lennard_jones_pair_force_top.sv]
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------
// input    | i_in_valid   | o_in_ready   | i_in_data  (lj_pkg::t_in)
// output   | o_out_valid  | i_out_ready  | o_out_data (lj_pkg::t_out)
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one pair accepted per cycle while the output buffer is not full; the result path
// is set by two 64-stage dividers and six 4-stage multiplier rows, and a result is
// offered once the output buffer holds it.
// reset clears all valid bits, the output buffer and loads the register defaults.
// a two-entry output buffer takes the pipeline's results; the whole pipeline
// holds only while that buffer is full, so nothing is lost or repeated.
module lennard_jones_pair_force_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  lj_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output lj_pkg::t_out o_out_data,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic [31:0]   r_cutoff_sq, r_sigma_sq, r_well_depth;
    logic          w_en;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq  <= 32'd409600;
            r_sigma_sq   <= 32'd65536;
            r_well_depth <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lj_pkg::CFG_CUTOFF_SQ:  r_cutoff_sq  <= i_cfg_data;
                lj_pkg::CFG_SIGMA_SQ:   r_sigma_sq   <= i_cfg_data;
                lj_pkg::CFG_WELL_DEPTH: r_well_depth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // separation per axis
    logic signed [31:0] w_first  [3];
    logic signed [31:0] w_second [3];
    logic [32:0]        w_diff   [3];
    logic               r_v1;
    logic [2:0][32:0]   r_mag1;
    logic [2:0]         r_negr1;

    assign w_first[0]  = i_in_data.first_x;
    assign w_first[1]  = i_in_data.first_y;
    assign w_first[2]  = i_in_data.first_z;
    assign w_second[0] = i_in_data.second_x;
    assign w_second[1] = i_in_data.second_y;
    assign w_second[2] = i_in_data.second_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = {w_second[i][31], w_second[i]} - {w_first[i][31], w_first[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_negr1[i] <= w_diff[i][32];
                r_mag1[i]  <= w_diff[i][32] ? 33'(-w_diff[i]) : w_diff[i];
            end
        end
    end

    // squares
    lj_pkg::t_side w_side1;
    logic          w_vsq;
    logic [63:0]   w_sq [3];
    lj_pkg::t_side w_side_sq;

    always_comb begin
        w_side1      = '0;
        w_side1.mag  = r_mag1;
        w_side1.negr = r_negr1;
    end

    for (genvar i = 0; i < 3; i++) begin : g_sq
        lj_pkg::t_side w_so;
        logic          w_vo;

        lj_mul u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v1),
            .i_a     (64'(r_mag1[i])),
            .i_b     (64'(r_mag1[i])),
            .i_cap   ({64{1'b1}}),
            .i_side  (w_side1),
            .o_valid (w_vo),
            .o_p     (w_sq[i]),
            .o_side  (w_so)
        );

        if (i == 0) begin : g_keep
            assign w_vsq     = w_vo;
            assign w_side_sq = w_so;
        end
    end

    // squared distance and cutoff test
    logic          r_v2, r_v3;
    logic [50:0]   r_dsum;
    lj_pkg::t_side r_side2, r_side3;
    lj_pkg::t_side n_side3;

    always_comb begin
        n_side3        = r_side2;
        n_side3.d      = r_dsum[31:0];
        n_side3.in_cut = (r_dsum <= 51'(r_cutoff_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= w_vsq;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dsum  <= 51'(w_sq[0]) + 51'(w_sq[1]) + 51'(w_sq[2]) + 51'd1;
            r_side2 <= w_side_sq;
            r_side3 <= n_side3;
        end
    end

    // s = sigma_sq / d
    logic          w_vd1;
    logic [63:0]   w_q1;
    lj_pkg::t_side w_sd1, w_sm1;

    lj_div u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_num   (64'(r_sigma_sq) << lj_pkg::FRAC_BITS),
        .i_rem0  (32'd0),
        .i_den   (r_side3.d),
        .i_side  (r_side3),
        .o_valid (w_vd1),
        .o_quo   (w_q1),
        .o_side  (w_sd1)
    );

    always_comb begin
        w_sm1     = w_sd1;
        w_sm1.aux = w_q1;
    end

    // s2 then s3
    logic          w_vm1, w_vm2;
    logic [63:0]   w_p1, w_p2;
    lj_pkg::t_side w_so1, w_so2;

    lj_mul u_s2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vd1),
        .i_a     (w_q1),
        .i_b     (w_q1),
        .i_cap   (lj_pkg::MID_CAP),
        .i_side  (w_sm1),
        .o_valid (w_vm1),
        .o_p     (w_p1),
        .o_side  (w_so1)
    );

    lj_mul u_s3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vm1),
        .i_a     (w_p1),
        .i_b     (w_so1.aux),
        .i_cap   (lj_pkg::MID_CAP),
        .i_side  (w_so1),
        .o_valid (w_vm2),
        .o_p     (w_p2),
        .o_side  (w_so2)
    );

    // attraction/repulsion factor u = |1 - 2*s3|
    logic          r_v4;
    logic [63:0]   r_s3;
    lj_pkg::t_side r_side4;
    lj_pkg::t_side n_side4;
    logic [63:0]   w_two_s3, w_one;
    logic          w_negf;

    assign w_one    = 64'd1 << lj_pkg::FRAC_BITS;
    assign w_two_s3 = w_p2 << 1;
    assign w_negf   = w_two_s3 > w_one;

    always_comb begin
        n_side4      = w_so2;
        n_side4.negf = w_negf;
        n_side4.aux  = w_negf ? (w_two_s3 - w_one) : (w_one - w_two_s3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_vm2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3    <= w_p2;
            r_side4 <= n_side4;
        end
    end

    // b = 24*eps*s3, c = b*u
    logic [63:0]   w_wd24;
    logic          w_vm3, w_vm4;
    logic [63:0]   w_p3, w_p4;
    lj_pkg::t_side w_so3, w_so4;

    assign w_wd24 = (64'(r_well_depth) << 4) + (64'(r_well_depth) << 3);

    lj_mul u_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_a     (w_wd24),
        .i_b     (r_s3),
        .i_cap   (lj_pkg::MID_CAP),
        .i_side  (r_side4),
        .o_valid (w_vm3),
        .o_p     (w_p3),
        .o_side  (w_so3)
    );

    lj_mul u_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vm3),
        .i_a     (w_p3),
        .i_b     (w_so3.aux),
        .i_cap   (lj_pkg::MID_CAP),
        .i_side  (w_so3),
        .o_valid (w_vm4),
        .o_p     (w_p4),
        .o_side  (w_so4)
    );

    // quotient overflow check for c * 2^F / d
    logic          r_v5;
    logic [63:0]   r_c;
    lj_pkg::t_side r_side5;
    lj_pkg::t_side n_side5;

    always_comb begin
        n_side5     = w_so4;
        n_side5.ovf = (w_p4 >> lj_pkg::SH_HI) >= 64'(w_so4.d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_vm4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c     <= w_p4;
            r_side5 <= n_side5;
        end
    end

    // f = c * 2^F / d
    logic          w_vd2;
    logic [63:0]   w_q2;
    lj_pkg::t_side w_sd2;

    lj_div u_div_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v5),
        .i_num   (r_c << lj_pkg::FRAC_BITS),
        .i_rem0  (r_side5.ovf ? 32'd0 : 32'(r_c >> lj_pkg::SH_HI)),
        .i_den   (r_side5.d),
        .i_side  (r_side5),
        .o_valid (w_vd2),
        .o_quo   (w_q2),
        .o_side  (w_sd2)
    );

    logic          r_v6;
    logic [63:0]   r_f;
    lj_pkg::t_side r_side6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= w_vd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f     <= (w_sd2.ovf || (w_q2 > lj_pkg::MID_CAP)) ? lj_pkg::MID_CAP : w_q2;
            r_side6 <= w_sd2;
        end
    end

    // force per axis = |r| * f
    logic          w_vf;
    logic [63:0]   w_pf [3];
    lj_pkg::t_side w_sf;

    for (genvar i = 0; i < 3; i++) begin : g_force
        lj_pkg::t_side w_so;
        logic          w_vo;
        logic          w_neg;

        assign w_neg = r_side6.negr[i] ^ r_side6.negf;

        lj_mul u_f (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v6),
            .i_a     (64'(r_side6.mag[i])),
            .i_b     (r_f),
            .i_cap   (w_neg ? 64'h8000_0001 : 64'h8000_0000),
            .i_side  (r_side6),
            .o_valid (w_vo),
            .o_p     (w_pf[i]),
            .o_side  (w_so)
        );

        if (i == 0) begin : g_keep
            assign w_vf = w_vo;
            assign w_sf = w_so;
        end
    end

    // clip, sign and cutoff masking
    lj_pkg::t_out w_res;
    logic [31:0]  w_fv [3];
    logic [2:0]   w_sat;

    always_comb begin
        logic        neg;
        logic [63:0] lim;
        logic [63:0] m;
        for (int i = 0; i < 3; i++) begin
            neg      = w_sf.negr[i] ^ w_sf.negf;
            lim      = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            w_sat[i] = w_pf[i] > lim;
            m        = w_sat[i] ? lim : w_pf[i];
            w_fv[i]  = neg ? 32'(-m) : m[31:0];
        end
        if (w_sf.in_cut) begin
            w_res.force_x   = w_fv[0];
            w_res.force_y   = w_fv[1];
            w_res.force_z   = w_fv[2];
            w_res.in_cutoff = 1'b1;
            w_res.saturated = |w_sat;
        end else begin
            w_res = '0;
        end
    end

    // two-entry output buffer
    logic         w_push, w_pop;
    logic [1:0]   r_cnt;
    lj_pkg::t_out r_buf0, r_buf1;

    assign w_en        = (r_cnt != 2'd2);
    assign o_in_ready  = w_en;
    assign w_push      = w_en && w_vf;
    assign w_pop       = (r_cnt != 2'd0) && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_buf0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_buf0 <= (r_cnt == 2'd2) ? r_buf1 : w_res;
            if (w_push && r_cnt == 2'd2) begin
                r_buf1 <= w_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_buf0 <= w_res;
            end else begin
                r_buf1 <= w_res;
            end
        end
    end

endmodule

[test/tb_lennard_jones_pair_force_top.sv]
`timescale 1ns / 1ps

module tb_lennard_jones_pair_force_top;

    localparam int          FB        = lj_pkg::FRAC_BITS;
    localparam logic [63:0] CAP62     = lj_pkg::MID_CAP;
    localparam int          LATENCY   = 159;
    localparam int          HOLD_CYCS = 400;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    lj_pkg::t_in  i_in_data;
    logic         o_out_valid;
    logic         i_out_ready;
    lj_pkg::t_out o_out_data;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    // predictor copy of the registers
    logic [31:0] cut_reg;
    logic [31:0] sig_reg;
    logic [31:0] eps_reg;

    lj_pkg::t_out force_queue[$];
    int           err_cnt;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_off;

    lennard_jones_pair_force_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // min(floor(a*b / 2^FB), cap) with an exact 128-bit product
    function automatic logic [63:0] mul_fix(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] cap);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p >> FB;
        if (q > {64'd0, cap})
            return cap;
        return q[63:0];
    endfunction

    // expected force for one particle pair
    function automatic lj_pkg::t_out pair_force(lj_pkg::t_in p);
        logic signed [32:0] r[3];
        logic [63:0]        mag[3];
        logic               negr[3];
        logic [63:0]        d, s, s2, s3, u, b, c, f, q, m, lim;
        logic [127:0]       fw;
        logic               negf, neg;
        logic [31:0]        comp[3];
        lj_pkg::t_out       res;
        r[0] = 33'(p.second_x) - 33'(p.first_x);
        r[1] = 33'(p.second_y) - 33'(p.first_y);
        r[2] = 33'(p.second_z) - 33'(p.first_z);
        d = 64'd1;
        for (int i = 0; i < 3; i++) begin
            negr[i] = r[i] < 0;
            mag[i]  = negr[i] ? 64'(-r[i]) : 64'(r[i]);
            d += (mag[i] * mag[i]) >> FB;
        end
        res = '0;
        if (d > {32'd0, cut_reg})
            return res;
        s  = ({32'd0, sig_reg} << FB) / d;
        s2 = mul_fix(s, s, CAP62);
        s3 = mul_fix(s2, s, CAP62);
        negf = (2 * s3) > (64'd1 << FB);
        u = negf ? 2 * s3 - (64'd1 << FB) : (64'd1 << FB) - 2 * s3;
        b = mul_fix(64'd24 * eps_reg, s3, CAP62);
        c = mul_fix(b, u, CAP62);
        q = c / d;
        if (q > (CAP62 >> FB)) begin
            f = CAP62;
        end else begin
            fw = ({64'd0, c} << FB) / {64'd0, d};
            f  = (fw > {64'd0, CAP62}) ? CAP62 : fw[63:0];
        end
        for (int i = 0; i < 3; i++) begin
            neg = negr[i] != negf;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            m = mul_fix(mag[i], f, lim + 1);
            if (m > lim) begin
                m = lim;
                res.saturated = 1'b1;
            end
            comp[i] = neg ? 32'(-m) : m[31:0];
        end
        res.force_x   = comp[0];
        res.force_y   = comp[1];
        res.force_z   = comp[2];
        res.in_cutoff = 1'b1;
        return res;
    endfunction

    // receiver: random stalls, long hold-off, result check
    always @(posedge i_clk) begin
        lj_pkg::t_out exp_res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (force_queue.size() == 0) begin
                    $error("unexpected result %h", o_out_data);
                    err_cnt++;
                end else begin
                    exp_res = force_queue.pop_front();
                    if (o_out_data.force_x !== exp_res.force_x) begin
                        $error("force_x exp %h got %h", exp_res.force_x, o_out_data.force_x);
                        err_cnt++;
                    end
                    if (o_out_data.force_y !== exp_res.force_y) begin
                        $error("force_y exp %h got %h", exp_res.force_y, o_out_data.force_y);
                        err_cnt++;
                    end
                    if (o_out_data.force_z !== exp_res.force_z) begin
                        $error("force_z exp %h got %h", exp_res.force_z, o_out_data.force_z);
                        err_cnt++;
                    end
                    if (o_out_data.in_cutoff !== exp_res.in_cutoff) begin
                        $error("in_cutoff exp %b got %b", exp_res.in_cutoff,
                               o_out_data.in_cutoff);
                        err_cnt++;
                    end
                    if (o_out_data.saturated !== exp_res.saturated) begin
                        $error("saturated exp %b got %b", exp_res.saturated,
                               o_out_data.saturated);
                        err_cnt++;
                    end
                end
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted in cycles
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCS) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // one pair transfer with random idle cycles before it; valid stays up
    // for a following transfer and is dropped by the idle loop or drain
    task automatic send_pair(lj_pkg::t_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        force_queue.push_back(pair_force(p));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // register write, only while the pipeline is drained
    task automatic write_reg(lj_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lj_pkg::CFG_CUTOFF_SQ:  cut_reg = val;
            lj_pkg::CFG_SIGMA_SQ:   sig_reg = val;
            lj_pkg::CFG_WELL_DEPTH: eps_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (force_queue.size() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic lj_pkg::t_in make_pair(logic [31:0] fx, logic [31:0] fy,
                                              logic [31:0] fz, logic [31:0] dx,
                                              logic [31:0] dy, logic [31:0] dz);
        lj_pkg::t_in p;
        p.first_x  = fx;
        p.first_y  = fy;
        p.first_z  = fz;
        p.second_x = fx + dx;
        p.second_y = fy + dy;
        p.second_z = fz + dz;
        return p;
    endfunction

    // separation mostly near sigma, sometimes anywhere
    function automatic lj_pkg::t_in rand_pair();
        logic [31:0] dl[3];
        int          sel;
        sel = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
            if (sel < 5)
                dl[i] = $signed($urandom_range(196608)) - 98304;
            else if (sel < 8)
                dl[i] = $signed($urandom_range(16384)) - 8192;
            else
                dl[i] = $urandom;
        end
        return make_pair($urandom, $urandom, $urandom, dl[0], dl[1], dl[2]);
    endfunction

    task automatic test_extremes();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(mx, mx, mx, 0, 0, 0));
        send_pair(make_pair(mn, mn, mn, 1, 0, 0));
        send_pair(make_pair(mn, mn, mn, mx, mx, mx));
        send_pair(make_pair(mx, mx, mx, mn, mn, mn));
        send_pair(make_pair(0, 0, 0, 32'h0001_0000, 0, 0));
        send_pair(make_pair(0, 0, 0, 32'hFFFF_0000, 0, 0));
        send_pair(make_pair(0, 0, 0, 32'h0001_2000, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 32'h0000_E000, 32'hFFFF_F000));
        send_pair(make_pair(0, 0, 0, 32'h0000_0100, 32'hFFFF_FF00, 1));
        send_pair(make_pair(5, 5, 5, 32'h0009_FFFF, 0, 0));
        send_pair(make_pair(5, 5, 5, 32'h000A_0001, 0, 0));
        send_pair(make_pair(0, 0, 0, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000));
        drain();
    endtask

    task automatic test_reg_extremes();
        write_reg(lj_pkg::CFG_CUTOFF_SQ, 32'hFFFF_FFFF);
        write_reg(lj_pkg::CFG_SIGMA_SQ, 32'hFFFF_FFFF);
        write_reg(lj_pkg::CFG_WELL_DEPTH, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_pair(make_pair(0, 0, 0, i * 32'h0000_4000, 1, i));
        send_pair(rand_pair());
        drain();
        write_reg(lj_pkg::CFG_CUTOFF_SQ, 0);
        write_reg(lj_pkg::CFG_SIGMA_SQ, 0);
        write_reg(lj_pkg::CFG_WELL_DEPTH, 0);
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 1, 0, 0));
        drain();
        write_reg(lj_pkg::CFG_CUTOFF_SQ, 1);
        write_reg(lj_pkg::CFG_SIGMA_SQ, 32'h0001_0000);
        write_reg(lj_pkg::CFG_WELL_DEPTH, 32'h0001_0000);
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 32'h0000_0200, 0, 0));
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_reg(lj_pkg::CFG_CUTOFF_SQ,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1600000));
        write_reg(lj_pkg::CFG_SIGMA_SQ,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
        write_reg(lj_pkg::CFG_WELL_DEPTH,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(300000));
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait (hold_off);
        for (int i = 0; i < 300; i++)
            send_pair(rand_pair());
        drain();
    endtask

    initial begin
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cut_reg        = 32'd409600;
        sig_reg        = 32'd65536;
        eps_reg        = 32'd65536;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = lj_pkg::CFG_CUTOFF_SQ;
        i_cfg_data     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random(300, 0, 0);
        test_backpressure();
        test_reg_extremes();
        test_random(250, 75, 0);
        test_random(250, 0, 75);
        test_random(250, 30, 30);
        test_random(100, 0, 0);

        if (err_cnt == 0 && force_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
